/* design/rmq_pkg.sv */
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block
// no dependencies; used by the top level, the checker and the bench

package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  typedef logic [1:0] rmq_branch_t;

  // branch codes as reported on the result channel
  localparam rmq_branch_t BR_TRACE = 2'd0;
  localparam rmq_branch_t BR_X     = 2'd1;
  localparam rmq_branch_t BR_Y     = 2'd2;
  localparam rmq_branch_t BR_Z     = 2'd3;

endpackage

/* design/rmq_sqrt_pipe.sv */
// rmq_sqrt_pipe: pipelined digit-by-digit integer square root of (rad << SH)
// one root bit per stage; depends on nothing but its parameters

module rmq_sqrt_pipe #(
  parameter int RW  = 18,
  parameter int SH  = 16,
  parameter int SBW = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [RW-1:0]                in_rad,
  input  logic [SBW-1:0]               in_side,
  output logic                         out_valid,
  output logic [(RW+SH+1)/2-1:0]       out_root,
  output logic [SBW-1:0]               out_side
);

  localparam int PAIRS = (RW + SH + 1) / 2;
  localparam int SW    = PAIRS;
  localparam int XW    = 2 * PAIRS;
  localparam int RMW   = SW + 2;

  logic           v_r    [PAIRS];
  logic [XW-1:0]  x_r    [PAIRS];
  logic [RMW-1:0] rem_r  [PAIRS];
  logic [SW-1:0]  root_r [PAIRS];
  logic [SBW-1:0] side_r [PAIRS];

  for (genvar g = 0; g < PAIRS; g++) begin : g_stage
    logic           v_i;
    logic [XW-1:0]  x_i;
    logic [RMW-1:0] rem_i;
    logic [SW-1:0]  root_i;
    logic [SBW-1:0] side_i;
    logic [RMW+1:0] rem2;
    logic [RMW+1:0] trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign x_i    = XW'(in_rad) << SH;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign x_i    = x_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign side_i = side_r[g-1];
    end

    assign rem2  = {rem_i, x_i[XW-1:XW-2]};
    assign trial = (RMW+2)'({root_i, 2'b01});
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= x_i << 2;
        rem_r[g]  <= ge ? RMW'(rem2 - trial) : RMW'(rem2);
        root_r[g] <= {root_i[SW-2:0], ge};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_valid = v_r[PAIRS-1];
  assign out_root  = root_r[PAIRS-1];
  assign out_side  = side_r[PAIRS-1];

endmodule

/* design/rmq_div_pipe.sv */
// rmq_div_pipe: three-lane pipelined restoring divider, rounded num*2^F/s
// one quotient bit per stage; magnitude clamped to 2^W; depends on nothing else

module rmq_div_pipe #(
  parameter int W   = 16,
  parameter int F   = 14,
  parameter int SW  = 18,
  parameter int SBW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W:0]   in_num [3],
  input  logic [SW-1:0]       in_s,
  input  logic [SBW-1:0]      in_side,
  output logic                out_valid,
  output logic signed [W+1:0] out_q [3],
  output logic [SBW-1:0]      out_side
);

  localparam int DVW = W + F + 3;
  localparam int DDW = SW + 1;
  localparam int RMW = SW + 2;
  localparam int NL  = 3;

  logic           v_r    [DVW];
  logic [DDW-1:0] d_r    [DVW];
  logic [SBW-1:0] side_r [DVW];
  logic [DVW-1:0] dvd_r  [DVW][NL];
  logic [RMW-1:0] rem_r  [DVW][NL];
  logic [DVW-1:0] quo_r  [DVW][NL];
  logic           neg_r  [DVW][NL];

  for (genvar g = 0; g < DVW; g++) begin : g_stage
    logic           v_i;
    logic [DDW-1:0] d_i;
    logic [SBW-1:0] side_i;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign d_i    = {in_s, 1'b0};
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign d_i    = d_r[g-1];
      assign side_i = side_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[g]    <= d_i;
        side_r[g] <= side_i;
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DVW-1:0] dvd_i;
      logic [RMW-1:0] rem_i;
      logic [DVW-1:0] quo_i;
      logic           neg_i;
      logic [RMW-1:0] r2;
      logic           ge;

      if (g == 0) begin : g_first
        logic [W:0] mag;
        assign mag   = in_num[l][W] ? W'(0) - in_num[l] : in_num[l];
        assign dvd_i = (DVW'(mag) << (F + 1)) + DVW'(in_s);
        assign rem_i = '0;
        assign quo_i = '0;
        assign neg_i = in_num[l][W];
      end else begin : g_next
        assign dvd_i = dvd_r[g-1][l];
        assign rem_i = rem_r[g-1][l];
        assign quo_i = quo_r[g-1][l];
        assign neg_i = neg_r[g-1][l];
      end

      assign r2 = {rem_i[RMW-2:0], dvd_i[DVW-1]};
      assign ge = r2 >= RMW'(d_i);

      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[g][l] <= dvd_i << 1;
          rem_r[g][l] <= ge ? r2 - RMW'(d_i) : r2;
          quo_r[g][l] <= {quo_i[DVW-2:0], ge};
          neg_r[g][l] <= neg_i;
        end
      end
    end
  end

  // clamp: anything above 2^W saturates the same way after the sign fix
  for (genvar l = 0; l < NL; l++) begin : g_out
    logic [DVW-1:0] quo;
    logic [W:0]     magc;
    assign quo  = quo_r[DVW-1][l];
    assign magc = (|quo[DVW-1:W]) ? {1'b1, {W{1'b0}}} : quo[W:0];
    always_comb begin
      if (d_r[DVW-1] == '0) begin
        out_q[l] = '0;
      end else if (neg_r[DVW-1][l]) begin
        out_q[l] = (W+2)'(0) - (W+2)'(magc);
      end else begin
        out_q[l] = (W+2)'(magc);
      end
    end
  end

  assign out_valid = v_r[DVW-1];
  assign out_side  = side_r[DVW-1];

endmodule

/* design/rotation_matrix_to_quaternion.sv */
// rotation_matrix_to_quaternion: top level, Shepperd conversion of a 3x3 matrix
// depends on rmq_pkg, rmq_sqrt_pipe and rmq_div_pipe
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+--------------------
//   input   | in        | in_m00 .. in_m22                        | in_valid / in_stall
//   result  | out       | out_quat_w/x/y/z, out_branch_taken      | out_valid / out_stall
//
// the pipe (Q1.14 by default) has one stage for branch select, one per root bit in
// the square root, one per quotient bit in the divider, then the output register
// an item enters every cycle unless in_stall; the whole pipe shares one advance enable
// while the output register holds an unaccepted item the pipe freezes and in_stall is high
// synchronous active-low reset clears only the valid bits

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quat_w,
  output logic signed [DATA_WIDTH-1:0] out_quat_x,
  output logic signed [DATA_WIDTH-1:0] out_quat_y,
  output logic signed [DATA_WIDTH-1:0] out_quat_z,
  output logic [1:0]                   out_branch_taken
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = W + 2;              // radicand, never above 2^F + 1.5*2^W
  localparam int SH  = F + 2;              // radicand scale so the root is 2*sqrt in Q.F
  localparam int SW  = (RW + SH + 1) / 2;  // root width
  localparam int NW  = W + 1;              // numerator width
  localparam int SBA = 2 + 3 * NW;         // sideband through the root
  localparam int SBB = 2 + W + 2;          // sideband through the divider

  logic en;

  // ---------------- stage a: trace, branch, radicand, numerators ----------------
  logic signed [W+2:0] e00, e11, e22, tr, one_c, rad_s;
  logic signed [W:0]   e01, e02, e10, e12, e20, e21;
  logic signed [W:0]   d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  rmq_branch_t         br_nxt;
  logic signed [W:0]   num_nxt [3];

  assign e00   = (W+3)'(in_m00);
  assign e11   = (W+3)'(in_m11);
  assign e22   = (W+3)'(in_m22);
  assign e01   = (W+1)'(in_m01);
  assign e02   = (W+1)'(in_m02);
  assign e10   = (W+1)'(in_m10);
  assign e12   = (W+1)'(in_m12);
  assign e20   = (W+1)'(in_m20);
  assign e21   = (W+1)'(in_m21);
  assign tr    = e00 + e11 + e22;
  assign one_c = {{(W+2-F){1'b0}}, 1'b1, {F{1'b0}}};

  assign d21_12 = e21 - e12;
  assign d02_20 = e02 - e20;
  assign d10_01 = e10 - e01;
  assign s01_10 = e01 + e10;
  assign s02_20 = e02 + e20;
  assign s12_21 = e12 + e21;

  // strict compares: ties fall through to the later branch
  always_comb begin
    if (tr > 0) begin
      br_nxt = BR_TRACE;
    end else if (in_m00 > in_m11 && in_m00 > in_m22) begin
      br_nxt = BR_X;
    end else if (in_m11 > in_m22) begin
      br_nxt = BR_Y;
    end else begin
      br_nxt = BR_Z;
    end
  end

  // numerators in component order, skipping the dominant component
  always_comb begin
    case (br_nxt)
      BR_TRACE: begin
        rad_s      = tr + one_c;
        num_nxt[0] = d21_12;
        num_nxt[1] = d02_20;
        num_nxt[2] = d10_01;
      end
      BR_X: begin
        rad_s      = one_c + e00 - e11 - e22;
        num_nxt[0] = d21_12;
        num_nxt[1] = s01_10;
        num_nxt[2] = s02_20;
      end
      BR_Y: begin
        rad_s      = one_c + e11 - e00 - e22;
        num_nxt[0] = d02_20;
        num_nxt[1] = s01_10;
        num_nxt[2] = s12_21;
      end
      default: begin
        rad_s      = one_c + e22 - e00 - e11;
        num_nxt[0] = d10_01;
        num_nxt[1] = s02_20;
        num_nxt[2] = s12_21;
      end
    endcase
  end

  logic              a_valid_r;
  rmq_branch_t       a_br_r;
  logic [RW-1:0]     a_rad_r;
  logic signed [W:0] a_num_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  // negative radicand is clamped to zero as a guard
  always_ff @(posedge clk) begin
    if (en) begin
      a_br_r  <= br_nxt;
      a_rad_r <= rad_s[W+2] ? '0 : rad_s[RW-1:0];
      a_num_r <= num_nxt;
    end
  end

  // ---------------- square root: S = floor(sqrt(rad << (F+2))) ----------------
  logic           b_valid;
  logic [SW-1:0]  b_root;
  logic [SBA-1:0] b_side;

  rmq_sqrt_pipe #(
    .RW  (RW),
    .SH  (SH),
    .SBW (SBA)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid_r),
    .in_rad    (a_rad_r),
    .in_side   ({a_br_r, a_num_r[0], a_num_r[1], a_num_r[2]}),
    .out_valid (b_valid),
    .out_root  (b_root),
    .out_side  (b_side)
  );

  // ---------------- dividers and the dominant component S/4 ----------------
  logic signed [W:0]   b_num [3];
  logic [SW:0]         dom_full;
  logic signed [W+1:0] dom_c;

  assign b_num[0] = b_side[3*NW-1:2*NW];
  assign b_num[1] = b_side[2*NW-1:NW];
  assign b_num[2] = b_side[NW-1:0];
  assign dom_full = ((SW+1)'(b_root) + (SW+1)'(2)) >> 2;
  assign dom_c    = (dom_full > (SW+1)'({1'b1, {W{1'b0}}})) ?
                    (W+2)'({1'b1, {W{1'b0}}}) : (W+2)'(dom_full);

  logic                c_valid;
  logic signed [W+1:0] c_q [3];
  logic [SBB-1:0]      c_side;

  rmq_div_pipe #(
    .W   (W),
    .F   (F),
    .SW  (SW),
    .SBW (SBB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid),
    .in_num    (b_num),
    .in_s      (b_root),
    .in_side   ({b_side[SBA-1:SBA-2], dom_c}),
    .out_valid (c_valid),
    .out_q     (c_q),
    .out_side  (c_side)
  );

  // ---------------- assemble, sign fix, saturate ----------------
  rmq_branch_t         c_br;
  logic signed [W+1:0] c_dom;
  logic signed [W+1:0] comp [4];
  logic signed [W+1:0] fixd [4];
  logic signed [W-1:0] sat  [4];

  assign c_br  = c_side[SBB-1:SBB-2];
  assign c_dom = c_side[W+1:0];

  always_comb begin
    case (c_br)
      BR_TRACE: begin
        comp[0] = c_dom;  comp[1] = c_q[0]; comp[2] = c_q[1]; comp[3] = c_q[2];
      end
      BR_X: begin
        comp[0] = c_q[0]; comp[1] = c_dom;  comp[2] = c_q[1]; comp[3] = c_q[2];
      end
      BR_Y: begin
        comp[0] = c_q[0]; comp[1] = c_q[1]; comp[2] = c_dom;  comp[3] = c_q[2];
      end
      default: begin
        comp[0] = c_q[0]; comp[1] = c_q[1]; comp[2] = c_q[2]; comp[3] = c_dom;
      end
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_fix
    // magnitudes stay within 2^W so negation cannot wrap
    assign fixd[k] = comp[0][W+1] ? (W+2)'(0) - comp[k] : comp[k];
    always_comb begin
      if (fixd[k] > $signed({2'b00, 1'b0, {(W-1){1'b1}}})) begin
        sat[k] = {1'b0, {(W-1){1'b1}}};
      end else if (fixd[k] < $signed({2'b11, 1'b1, {(W-1){1'b0}}})) begin
        sat[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat[k] = fixd[k][W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_r;
  logic signed [W-1:0] out_quat_w_r, out_quat_x_r, out_quat_y_r, out_quat_z_r;
  rmq_branch_t         out_branch_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quat_w_r <= sat[0];
      out_quat_x_r <= sat[1];
      out_quat_y_r <= sat[2];
      out_quat_z_r <= sat[3];
      out_branch_r <= c_br;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_quat_w       = out_quat_w_r;
  assign out_quat_x       = out_quat_x_r;
  assign out_quat_y       = out_quat_y_r;
  assign out_quat_z       = out_quat_z_r;
  assign out_branch_taken = out_branch_r;

endmodule

/* design/rmq_checker.sv */
// rmq_checker: port-level assertions for rotation_matrix_to_quaternion
// depends on rmq_pkg; bound to the top level at the end of this file

module rmq_checker
  import rmq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_quat_w,
  input logic signed [DATA_WIDTH-1:0] out_quat_x,
  input logic signed [DATA_WIDTH-1:0] out_quat_y,
  input logic signed [DATA_WIDTH-1:0] out_quat_z,
  input logic [1:0]                   out_branch_taken
);

  // a held item keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quat_w) && $stable(out_quat_x)
      && $stable(out_quat_y) && $stable(out_quat_z) && $stable(out_branch_taken))
    else $error("held result changed");

  // a blocked output backs up into the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled while output is held");

  a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quat_w >= 0)
    else $error("scalar part negative");

  // trace branch has radicand above one so the scalar is at least one half
  a_trace_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_taken == BR_TRACE |-> out_quat_w != 0)
    else $error("trace branch with zero scalar");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_quat_w       (out_quat_w),
  .out_quat_x       (out_quat_x),
  .out_quat_y       (out_quat_y),
  .out_quat_z       (out_quat_z),
  .out_branch_taken (out_branch_taken)
);

/* dv/tb_top.sv */
// tb_top: self-checking bench for rotation_matrix_to_quaternion (Shepperd conversion)
// depends on rmq_pkg and the block; directed table first, then random matrices
// checked against an in-bench predictor of the fixed-point conversion

`timescale 1ns / 100ps

module tb_top;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int N_RANDOM = 1730;
  localparam int PIPE_LAT = 52;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [DW-1:0] fix_t;

  typedef struct packed {
    fix_t w;
    fix_t x;
    fix_t y;
    fix_t z;
    rmq_branch_t br;
  } quat_t;

  // one matrix row by row, plus an optional typed-in expectation
  typedef struct {
    fix_t m [9];
    bit has_exp;
    quat_t exp_q;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fix_t in_m [9];
  logic out_valid;
  logic out_stall = 1'b0;
  fix_t out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [1:0] out_branch_taken;

  quat_t quat_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int branch_count [4];
  int idle_send_pct = 0;
  int idle_recv_pct = 0;
  bit hold_recv = 1'b0;
  int quiet_cycles = 0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    foreach (in_m[i]) in_m[i] = '0;
  end

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_branch_taken(out_branch_taken)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor(sqrt(v)), bit by bit from the top
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // num * 2^FB / s, rounded to nearest with ties away from zero
  function automatic longint round_div(longint num, longint unsigned s);
    longint unsigned mag, q;
    if (s == 0) return 0;
    mag = (num < 0) ? longint'(-num) : num;
    q = ((mag << (FB + 1)) + s) / (s << 1);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic fix_t clip_fix(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return fix_t'(v);
  endfunction

  function automatic quat_t shepperd_quat(fix_t mt [9]);
    longint m [9];
    longint tr, rad, q [4];
    longint unsigned s;
    longint one;
    rmq_branch_t br;
    quat_t r;
    one = longint'(1) << FB;
    foreach (m[i]) m[i] = mt[i];
    tr = m[0] + m[4] + m[8];
    // strict compares: ties on the diagonal fall through to later branches
    if (tr > 0) begin
      br = BR_TRACE;
      rad = tr + one;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br = BR_X;
      rad = one + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      br = BR_Y;
      rad = one + m[4] - m[0] - m[8];
    end else begin
      br = BR_Z;
      rad = one + m[8] - m[0] - m[4];
    end
    if (rad < 0) rad = 0;
    s = int_sqrt(longint'(rad) << (FB + 2));
    case (br)
      BR_TRACE: begin
        q[0] = (s + 2) >> 2;
        q[1] = round_div(m[7] - m[5], s);
        q[2] = round_div(m[2] - m[6], s);
        q[3] = round_div(m[3] - m[1], s);
      end
      BR_X: begin
        q[0] = round_div(m[7] - m[5], s);
        q[1] = (s + 2) >> 2;
        q[2] = round_div(m[1] + m[3], s);
        q[3] = round_div(m[2] + m[6], s);
      end
      BR_Y: begin
        q[0] = round_div(m[2] - m[6], s);
        q[1] = round_div(m[1] + m[3], s);
        q[2] = (s + 2) >> 2;
        q[3] = round_div(m[5] + m[7], s);
      end
      default: begin
        q[0] = round_div(m[3] - m[1], s);
        q[1] = round_div(m[2] + m[6], s);
        q[2] = round_div(m[5] + m[7], s);
        q[3] = (s + 2) >> 2;
      end
    endcase
    // sign fix comes before saturation; a zero scalar is left alone
    if (q[0] < 0) foreach (q[i]) q[i] = -q[i];
    r.w = clip_fix(q[0]);
    r.x = clip_fix(q[1]);
    r.y = clip_fix(q[2]);
    r.z = clip_fix(q[3]);
    r.br = br;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = quat_queue.pop_front();
        if (out_quat_w !== e.w) report_mismatch("quat_w", out_quat_w, e.w);
        if (out_quat_x !== e.x) report_mismatch("quat_x", out_quat_x, e.x);
        if (out_quat_y !== e.y) report_mismatch("quat_y", out_quat_y, e.y);
        if (out_quat_z !== e.z) report_mismatch("quat_z", out_quat_z, e.z);
        if (out_branch_taken !== e.br)
          report_mismatch("branch_taken", out_branch_taken, e.br);
      end
      results_seen++;
    end
  end

  // receiver: random stall, or a forced hold-off
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < idle_recv_pct);
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("rotation_matrix_to_quaternion test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offers one item, holds it until taken; expectation queued on acceptance
  task automatic send_item(fix_t mt [9], bit has_exp, quat_t exp_q);
    quat_t p;
    while ($urandom_range(99) < idle_send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    foreach (mt[i]) in_m[i] <= mt[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = shepperd_quat(mt);
    // a typed-in row checks the predictor as well
    if (has_exp && p !== exp_q) report_mismatch("table row vs predictor", 1, 0);
    quat_queue.push_back(has_exp ? exp_q : p);
    branch_count[p.br]++;
    items_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fix_t rand_fix(int lo, int hi);
    return fix_t'($urandom_range(hi - lo) + lo);
  endfunction

  // random matrix: half near-rotations with mixed dominant axes, the rest noise or diagonal ties and extremes
  function automatic void rand_matrix(output fix_t mt [9]);
    int kind;
    int d;
    kind = $urandom_range(9);
    if (kind < 2) begin
      foreach (mt[i]) mt[i] = fix_t'($urandom());
    end else if (kind < 7) begin
      // well-formed-ish: diagonal picks the branch, off-diagonal within -16384..16384
      d = $urandom_range(3);
      foreach (mt[i]) mt[i] = rand_fix(-16384, 16384);
      mt[0] = rand_fix(-16384, 16384);
      mt[4] = rand_fix(-16384, 16384);
      mt[8] = rand_fix(-16384, 16384);
      if (d != 0) begin
        mt[0] = -mt[0] < 0 ? mt[0] : -mt[0];
        mt[4] = -mt[4] < 0 ? mt[4] : -mt[4];
        mt[8] = -mt[8] < 0 ? mt[8] : -mt[8];
        mt[(d - 1) * 4] = rand_fix(-4000, 16384);
      end
    end else begin
      // diagonal ties and extremes
      foreach (mt[i]) mt[i] = fix_t'($urandom());
      mt[0] = ($urandom_range(1)) ? 16'sh8000 : rand_fix(-20000, 0);
      mt[4] = ($urandom_range(1)) ? mt[0] : rand_fix(-20000, 0);
      mt[8] = ($urandom_range(1)) ? mt[4] : rand_fix(-20000, 0);
    end
  endfunction

  function automatic dir_row_t mk_row(int a0, int a1, int a2, int a3, int a4,
                                      int a5, int a6, int a7, int a8);
    dir_row_t r;
    r.m = '{fix_t'(a0), fix_t'(a1), fix_t'(a2), fix_t'(a3), fix_t'(a4),
            fix_t'(a5), fix_t'(a6), fix_t'(a7), fix_t'(a8)};
    r.has_exp = 1'b0;
    r.exp_q = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_exp(dir_row_t r, int w, int x, int y, int z,
                                      rmq_branch_t br);
    r.has_exp = 1'b1;
    r.exp_q = '{fix_t'(w), fix_t'(x), fix_t'(y), fix_t'(z), br};
    return r;
  endfunction

  dir_row_t dir_table [$];

  initial begin
    fix_t mt [9];
    int hold_len;
    int settle;
    foreach (branch_count[i]) branch_count[i] = 0;

    // identity and half-turns read straight off the formulas
    dir_table.push_back(mk_exp(mk_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                               16384, 0, 0, 0, BR_TRACE));
    dir_table.push_back(mk_exp(mk_row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
                               0, 16384, 0, 0, BR_X));
    dir_table.push_back(mk_exp(mk_row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384),
                               0, 0, 16384, 0, BR_Y));
    dir_table.push_back(mk_exp(mk_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
                               0, 0, 0, 16384, BR_Z));
    // all-zero matrix: trace zero, full tie on the diagonal goes to z
    dir_table.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // 90 degree turns about each axis
    dir_table.push_back(mk_row(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
    dir_table.push_back(mk_row(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
    dir_table.push_back(mk_row(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    // negative scalar triggers the sign fix in each non-trace branch
    dir_table.push_back(mk_row(16384, 0, 0, 0, -16384, 3000, 0, -3000, -16384));
    dir_table.push_back(mk_row(-16384, 0, -3000, 0, 16384, 0, 3000, 0, -16384));
    dir_table.push_back(mk_row(-16384, 3000, 0, -3000, -16384, 0, 0, 0, 16384));
    // ties between pairs of diagonal entries
    dir_table.push_back(mk_row(-8000, 100, 0, 200, -8000, 0, 0, 0, -9000));
    dir_table.push_back(mk_row(-8000, 0, 300, 0, -9000, 0, 400, 0, -8000));
    dir_table.push_back(mk_row(-9000, 0, 0, 0, -8000, 500, 0, 600, -8000));
    // extremes: saturation in every field and both field limits
    dir_table.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767));
    dir_table.push_back(mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768));
    dir_table.push_back(mk_row(-32768, 32767, -32768, 32767, -32768, 32767,
                               -32768, 32767, -32768));
    dir_table.push_back(mk_row(1, -32768, 32767, -32768, 0, -32768, 32767, 32767, 0));
    dir_table.push_back(mk_row(-16384, 32767, 32767, 32767, -16384, 32767,
                               -32768, -32768, -16384));
    dir_table.push_back(mk_row(32767, 0, 0, 0, -32768, 0, 0, 0, -32768));
    dir_table.push_back(mk_row(-32768, -1, -1, -1, -32768, -1, -1, -1, -32767));

    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[k]) send_item(dir_table[k].m, dir_table[k].has_exp,
                                     dir_table[k].exp_q);
    drop_valid();

    // sender pauses until everything has drained
    while (quat_queue.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // idling schedule by thirds of the random part
      if (n < N_RANDOM / 3) begin
        idle_send_pct = 27;
        idle_recv_pct = 47;
      end else if (n < 2 * N_RANDOM / 3) begin
        idle_send_pct = 47;
        idle_recv_pct = 27;
      end else begin
        idle_send_pct = 0;
        idle_recv_pct = 0;
      end
      // long receiver hold-off with the sender still pushing: pipe fills, input stalls
      if (n == 200 || n == 1400) begin
        fork
          begin
            hold_len = 150 + $urandom_range(100);
            hold_recv = 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      // sender drains to empty once mid-run
      if (n == 900) begin
        drop_valid();
        while (quat_queue.size() != 0) @(posedge clk);
      end
      rand_matrix(mt);
      send_item(mt, 1'b0, '0);
    end
    drop_valid();

    settle = 0;
    while (quat_queue.size() != 0) @(posedge clk);
    while (settle < 2 * PIPE_LAT) begin
      @(posedge clk);
      settle++;
    end

    $display("covered %0d matrices: trace %0d, x %0d, y %0d, z %0d branch",
             items_sent, branch_count[0], branch_count[1], branch_count[2],
             branch_count[3]);
    $display("stall patterns on both sides, receiver hold-offs and full drains");
    if (mismatches == 0 && quat_queue.size() == 0) begin
      $display("rotation_matrix_to_quaternion test passed");
    end else begin
      $display("rotation_matrix_to_quaternion test failed");
    end
    $finish;
  end

endmodule
